>>> sv/fgcs_pkg.sv
// Package for the frame gate, crop and swizzle block.
// Holds field widths, register indexes, item kinds and the crop window type.
// No dependencies.
package fgcs_pkg;

  localparam int MAX_DIM = 8192;

  localparam int TS_W    = 63;
  localparam int COORD_W = 13;
  localparam int PIX_W   = 32;
  localparam int OP_W    = 2;
  localparam int MIN_W   = 30;
  localparam int REG_W   = 16;
  localparam int WIN_W   = 18;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  localparam logic [OP_W-1:0] OP_FRAME = 2'd0;
  localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
  localparam logic [OP_W-1:0] OP_SNAP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUSPENDED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_CHANNELS = 3'd7;

  localparam logic [MIN_W-1:0] MIN_INTERVAL_RESET = 30'd33333333;
  localparam logic [7:0]       ALPHA_OPAQUE       = 8'd255;

  // Clamped crop window: columns x0 <= x < x1, rows y0 <= y < y1.
  typedef struct packed {
    logic signed [WIN_W-1:0] x0;
    logic signed [WIN_W-1:0] x1;
    logic signed [WIN_W-1:0] y0;
    logic signed [WIN_W-1:0] y1;
  } window_t;

endpackage

>>> sv/fgcs_window.sv
// Crop window clamp for the frame gate, crop and swizzle block.
// Registers the window, clamped to the frame, from the crop registers.
// Depends on fgcs_pkg.
module fgcs_window (
  input  logic                            clk,
  input  logic                            crop_enable,
  input  logic signed [fgcs_pkg::REG_W-1:0] region_left,
  input  logic signed [fgcs_pkg::REG_W-1:0] region_top,
  input  logic signed [fgcs_pkg::REG_W-1:0] region_width,
  input  logic signed [fgcs_pkg::REG_W-1:0] region_height,
  output fgcs_pkg::window_t               window
);
  import fgcs_pkg::*;

  localparam logic signed [WIN_W-1:0] MaxDimS = WIN_W'(MAX_DIM);

  logic signed [WIN_W-1:0] left_s, top_s, right_s, bottom_s;
  window_t                 window_next;

  always_comb begin
    left_s   = WIN_W'(region_left);
    top_s    = WIN_W'(region_top);
    right_s  = left_s + WIN_W'(region_width);
    bottom_s = top_s + WIN_W'(region_height);
    if (crop_enable) begin
      window_next.x0 = (left_s < 0) ? '0 : left_s;
      window_next.y0 = (top_s < 0) ? '0 : top_s;
      window_next.x1 = (right_s > MaxDimS) ? MaxDimS : right_s;
      window_next.y1 = (bottom_s > MaxDimS) ? MaxDimS : bottom_s;
    end else begin
      window_next.x0 = '0;
      window_next.y0 = '0;
      window_next.x1 = MaxDimS;
      window_next.y1 = MaxDimS;
    end
  end

  always_ff @(posedge clk) begin
    window <= window_next;
  end

endmodule

>>> sv/fgcs_gate.sv
// Frame gate for the frame gate, crop and swizzle block.
// Holds the rate limit, snap request and open frame state.
// Depends on fgcs_pkg.
module fgcs_gate (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             fire,
  input  logic [fgcs_pkg::OP_W-1:0]        opcode,
  input  logic [fgcs_pkg::TS_W-1:0]        timestamp,
  input  logic [fgcs_pkg::MIN_W-1:0]       min_interval,
  input  logic                             suspended,
  output logic                             frame_open
);
  import fgcs_pkg::*;

  logic [TS_W-1:0] last_kept_time;
  logic            snap_pending;
  logic [TS_W:0]   diff;
  logic            limit_on;
  logic            early;

  always_comb begin
    diff     = {1'b0, timestamp} - {1'b0, last_kept_time};
    limit_on = (min_interval != '0);
    early    = limit_on && (diff[TS_W] || (diff[TS_W-1:0] < TS_W'(min_interval)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_kept_time <= '0;
      snap_pending   <= 1'b0;
      frame_open     <= 1'b0;
    end else if (fire) begin
      case (opcode)
        OP_FRAME: begin
          if (early) begin
            frame_open <= 1'b0;
          end else begin
            if (limit_on) begin
              last_kept_time <= timestamp;
            end
            if (suspended && !snap_pending) begin
              frame_open <= 1'b0;
            end else begin
              snap_pending <= 1'b0;
              frame_open   <= 1'b1;
            end
          end
        end
        OP_SNAP: begin
          snap_pending <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> sv/frame_gate_crop_swizzle.sv
// Top level of the frame gate, crop and swizzle block.
// Holds the registers, the input stage and the output stage.
// Depends on fgcs_pkg, fgcs_window and fgcs_gate.
//
//   Channel   Signals                            Contents
//   s_axis    tvalid tready tdata[127:0] tuser   items: frame start, pixel, snap request
//   m_axis    tvalid tready tdata[63:0]          converted pixels
//   cfg       cfg_we cfg_index cfg_data          register writes
//
// One item is taken per cycle unless m_axis stalls; kept pixels pass both stages.
// The input stage moves on unless a kept pixel waits on a full output register.
// Synchronous reset clears the stage valids and frame state and presets the registers.
// The clamped crop window is registered after the crop registers that a write sets.
module frame_gate_crop_swizzle (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // timestamp[62:0], pixel_x[75:63], pixel_y[88:76], pixel_value[120:89], zeros above
  input  logic [fgcs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // opcode[1:0]
  input  logic [fgcs_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_pixel[31:0], out_x[44:32], out_y[57:45], zeros above
  output logic [fgcs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [fgcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fgcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fgcs_pkg::*;

  // Registers.
  logic [MIN_W-1:0]        min_interval;
  logic                    suspended;
  logic                    crop_enable;
  logic signed [REG_W-1:0] region_left;
  logic signed [REG_W-1:0] region_top;
  logic signed [REG_W-1:0] region_width;
  logic signed [REG_W-1:0] region_height;
  logic                    swap_channels;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval  <= MIN_INTERVAL_RESET;
      suspended     <= 1'b0;
      crop_enable   <= 1'b0;
      region_left   <= '0;
      region_top    <= '0;
      region_width  <= '0;
      region_height <= '0;
      swap_channels <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_INTERVAL:  min_interval  <= cfg_data[MIN_W-1:0];
        REG_SUSPENDED:     suspended     <= cfg_data[0];
        REG_CROP_ENABLE:   crop_enable   <= cfg_data[0];
        REG_REGION_LEFT:   region_left   <= cfg_data[REG_W-1:0];
        REG_REGION_TOP:    region_top    <= cfg_data[REG_W-1:0];
        REG_REGION_WIDTH:  region_width  <= cfg_data[REG_W-1:0];
        REG_REGION_HEIGHT: region_height <= cfg_data[REG_W-1:0];
        REG_SWAP_CHANNELS: swap_channels <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  window_t window;

  fgcs_window u_window (
    .clk           (clk),
    .crop_enable   (crop_enable),
    .region_left   (region_left),
    .region_top    (region_top),
    .region_width  (region_width),
    .region_height (region_height),
    .window        (window)
  );

  // Input stage.
  logic               in_valid;
  logic [OP_W-1:0]    in_op;
  logic [TS_W-1:0]    in_ts;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [PIX_W-1:0]   in_pix;

  logic frame_open;
  logic out_free;
  logic keep;
  logic advance;
  logic signed [WIN_W-1:0] x_s, y_s;
  logic [PIX_W-1:0]   pix_next;
  logic [COORD_W-1:0] x_next, y_next;
  logic [WIN_W-1:0]   dx, dy;

  always_comb begin
    x_s  = WIN_W'($signed({1'b0, in_x}));
    y_s  = WIN_W'($signed({1'b0, in_y}));
    keep = (in_op == OP_PIXEL) && frame_open &&
           (x_s >= window.x0) && (x_s < window.x1) &&
           (y_s >= window.y0) && (y_s < window.y1);
    dx     = WIN_W'(x_s - window.x0);
    dy     = WIN_W'(y_s - window.y0);
    x_next = dx[COORD_W-1:0];
    y_next = dy[COORD_W-1:0];
    if (swap_channels) begin
      pix_next = {ALPHA_OPAQUE, in_pix[7:0], in_pix[15:8], in_pix[23:16]};
    end else begin
      pix_next = in_pix;
    end
    out_free      = !m_axis_tvalid || m_axis_tready;
    advance       = in_valid && (out_free || !keep);
    s_axis_tready = !in_valid || advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op  <= s_axis_tuser;
      in_ts  <= s_axis_tdata[TS_W-1:0];
      in_x   <= s_axis_tdata[TS_W+COORD_W-1:TS_W];
      in_y   <= s_axis_tdata[TS_W+2*COORD_W-1:TS_W+COORD_W];
      in_pix <= s_axis_tdata[TS_W+2*COORD_W+PIX_W-1:TS_W+2*COORD_W];
    end
  end

  fgcs_gate u_gate (
    .clk          (clk),
    .rst          (rst),
    .fire         (advance),
    .opcode       (in_op),
    .timestamp    (in_ts),
    .min_interval (min_interval),
    .suspended    (suspended),
    .frame_open   (frame_open)
  );

  // Output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid && keep) begin
      m_axis_tdata <= {(OUT_DATA_W - PIX_W - 2*COORD_W)'(0), y_next, x_next, pix_next};
    end
  end

endmodule
